// ----- src/pcls_pkg.sv -----
// Shared types, constants and the tangent table for the point cloud to laser scan block.
// No dependencies; used by pcls_geom, pcls_mem and point_cloud_to_laser_scan_top.
package pcls_pkg;

    // Default beam count, one beam per degree
    localparam int BEAMS_DEF = 360;

    // Stored range that marks an empty beam
    localparam logic [15:0] EMPTY_RANGE = 16'hFFFF;

    // Register reset value for the height limit
    localparam logic [14:0] Z_LIMIT_RST = 15'd100;

    // Opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Tangent table scale and last entry used in the octant search
    localparam logic [29:0] TAN_SCALE = 30'd1000000000;
    localparam logic [5:0]  TAN_LAST  = 6'd44;

    // Angle codes are 2*floor(deg) + (1 when not a whole degree)
    localparam logic [7:0] CODE_ZERO  = 8'd0;
    localparam logic [7:0] CODE_DIAG  = 8'd90;
    localparam logic [7:0] CODE_RIGHT = 8'd180;

    // Bin arithmetic in degrees
    localparam logic [9:0] HALF_TURN = 10'd180;
    localparam logic [9:0] FULL_TURN = 10'd360;

    // Result of the angle/range unit
    typedef struct packed {
        logic        done;
        logic [7:0]  code;
        logic [15:0] range;
    } geom_res_t;

    // tan(k degrees) * 1e9, rounded to nearest
    function automatic logic [29:0] tan_e9(input logic [5:0] k);
        logic [29:0] t;
        unique case (k)
            6'd1:  t = 30'd17455065;
            6'd2:  t = 30'd34920769;
            6'd3:  t = 30'd52407779;
            6'd4:  t = 30'd69926812;
            6'd5:  t = 30'd87488664;
            6'd6:  t = 30'd105104235;
            6'd7:  t = 30'd122784561;
            6'd8:  t = 30'd140540835;
            6'd9:  t = 30'd158384440;
            6'd10: t = 30'd176326981;
            6'd11: t = 30'd194380309;
            6'd12: t = 30'd212556562;
            6'd13: t = 30'd230868191;
            6'd14: t = 30'd249328003;
            6'd15: t = 30'd267949192;
            6'd16: t = 30'd286745386;
            6'd17: t = 30'd305730681;
            6'd18: t = 30'd324919696;
            6'd19: t = 30'd344327613;
            6'd20: t = 30'd363970234;
            6'd21: t = 30'd383864035;
            6'd22: t = 30'd404026226;
            6'd23: t = 30'd424474816;
            6'd24: t = 30'd445228685;
            6'd25: t = 30'd466307658;
            6'd26: t = 30'd487732589;
            6'd27: t = 30'd509525449;
            6'd28: t = 30'd531709432;
            6'd29: t = 30'd554309051;
            6'd30: t = 30'd577350269;
            6'd31: t = 30'd600860619;
            6'd32: t = 30'd624869352;
            6'd33: t = 30'd649407593;
            6'd34: t = 30'd674508517;
            6'd35: t = 30'd700207538;
            6'd36: t = 30'd726542528;
            6'd37: t = 30'd753554050;
            6'd38: t = 30'd781285627;
            6'd39: t = 30'd809784033;
            6'd40: t = 30'd839099631;
            6'd41: t = 30'd869286738;
            6'd42: t = 30'd900404044;
            6'd43: t = 30'd932515086;
            6'd44: t = 30'd965688775;
            default: t = 30'd0;
        endcase
        return t;
    endfunction

endpackage

// ----- src/pcls_geom.sv -----
// Iterative azimuth and planar range unit: binary search over the tangent table
// plus a bit-pair square root, 16 iterations. Depends on pcls_pkg.
module pcls_geom
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [15:0]          ax,
    input  logic [15:0]          ay,
    output pcls_pkg::geom_res_t  res
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  iter_reg;
    logic [5:0]  lo_reg;
    logic        eq_reg;
    logic [45:0] lhs_reg;
    logic [15:0] a_reg;
    logic        mirror_reg;
    logic        special_reg;
    logic [7:0]  spec_code_reg;
    logic [31:0] s_reg;
    logic [31:0] root_reg;

    logic        search;
    logic [5:0]  step;
    logic [5:0]  cand;
    logic [45:0] rhs;
    logic        take;
    logic [31:0] sbit;
    logic [31:0] trial;
    logic        ge;
    logic        odd;
    logic [6:0]  oct_code;
    logic [6:0]  ce;
    logic [7:0]  mir_code;

    // Octant search step: one table compare per cycle over the first six iterations
    always_comb
    begin
        search = (iter_reg < 4'd6);
        step   = 6'd32 >> iter_reg[2:0];
        cand   = lo_reg + step;
        rhs    = 46'(a_reg) * 46'(pcls_pkg::tan_e9(cand));
        take   = search && (cand <= pcls_pkg::TAN_LAST) && (lhs_reg >= rhs);
    end

    // Square root step: two bits of the radicand per cycle
    always_comb
    begin
        sbit  = 32'd1 << (5'd30 - {iter_reg, 1'b0});
        trial = root_reg + sbit;
        ge    = (s_reg >= trial);
    end

    // Angle code from the search result, mirrored for the upper octant
    always_comb
    begin
        odd      = !eq_reg;
        oct_code = {lo_reg, odd};
        ce       = 7'(lo_reg) + 7'(odd);
        mir_code = 8'(pcls_pkg::CODE_RIGHT - {ce, 1'b0}) + 8'(odd);
    end

    assign res.done  = done_reg;
    assign res.code  = special_reg ? spec_code_reg :
                       (mirror_reg ? mir_code : {1'b0, oct_code});
    assign res.range = root_reg[15:0];

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (iter_reg == 4'd15);
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 4'd1;
                if (iter_reg == 4'd15)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_reg   <= '0;
            eq_reg   <= 1'b0;
            root_reg <= '0;
            s_reg    <= 32'(ax) * 32'(ax) + 32'(ay) * 32'(ay);
            if (ay < ax)
            begin
                lhs_reg    <= 46'(ay) * 46'(pcls_pkg::TAN_SCALE);
                a_reg      <= ax;
                mirror_reg <= 1'b0;
            end
            else
            begin
                lhs_reg    <= 46'(ax) * 46'(pcls_pkg::TAN_SCALE);
                a_reg      <= ay;
                mirror_reg <= 1'b1;
            end
            // Axis and diagonal cases are exact
            priority if (ay == 16'd0)
            begin
                special_reg   <= 1'b1;
                spec_code_reg <= pcls_pkg::CODE_ZERO;
            end
            else if (ax == 16'd0)
            begin
                special_reg   <= 1'b1;
                spec_code_reg <= pcls_pkg::CODE_RIGHT;
            end
            else if (ax == ay)
            begin
                special_reg   <= 1'b1;
                spec_code_reg <= pcls_pkg::CODE_DIAG;
            end
            else
            begin
                special_reg   <= 1'b0;
                spec_code_reg <= pcls_pkg::CODE_ZERO;
            end
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                lo_reg <= cand;
                eq_reg <= (lhs_reg == rhs);
            end
            if (ge)
            begin
                s_reg    <= s_reg - trial;
                root_reg <= (root_reg >> 1) + sbit;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
        end
    end

endmodule

// ----- src/pcls_mem.sv -----
// Per-beam minimum range store: one write port, one registered read port,
// and a clearing pass after reset. Depends on pcls_pkg.
module pcls_mem
#(
    parameter int BEAMS = pcls_pkg::BEAMS_DEF,
    parameter int AW    = $clog2(BEAMS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    output logic          busy
);

    logic [15:0]   mem [BEAMS];
    logic [15:0]   rd_data_reg;
    logic          busy_reg;
    logic [AW-1:0] clr_reg;

    assign busy    = busy_reg;
    assign rd_data = rd_data_reg;

    // Clearing pass, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end
        else if (busy_reg)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == AW'(BEAMS - 1))
                busy_reg <= 1'b0;
        end
    end

    // Storage array
    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_reg] <= pcls_pkg::EMPTY_RANGE;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // No port writes while the clearing pass runs
    a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !wr_en)
        else $error("beam store written during clearing pass");

endmodule

// ----- src/point_cloud_to_laser_scan_top.sv -----
// Top level of the point cloud to laser scan block: sequencer, config register, output word.
// Depends on pcls_pkg, pcls_geom and pcls_mem.
//
//  channel | handshake           | word
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | opcode, x_mm, y_mm, z_mm, drain_beam
//  out     | out_valid/out_stall | beam_number, range_mm, hit
//  cfg     | cfg_valid/cfg_ready | z_limit_mm
//
// A kept point goes through the geometry unit, then the store read and update; a point
// dropped for height is taken without leaving idle, one dropped for its angle after the
// geometry unit; a drain reads the store and then waits for the output register.
// After reset the beam store is swept with in_stall high.
// One item is in work at a time; the output register holds a drained word while
// further points are taken, and a drain waits only for that register to free.
module point_cloud_to_laser_scan_top
#(
    parameter int BEAMS = pcls_pkg::BEAMS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [15:0] x_mm,
    input  logic signed [15:0] y_mm,
    input  logic signed [15:0] z_mm,
    input  logic [8:0]         drain_beam,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [8:0]         beam_number,
    output logic [15:0]        range_mm,
    output logic               hit,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        z_limit_mm
);

    localparam int AW = $clog2(BEAMS);

    typedef enum logic [1:0] { S_IDLE, S_GEOM, S_UPD, S_DRAIN } state_t;

    state_t              state_reg;
    logic                out_valid_reg;
    logic [8:0]          beam_out_reg;
    logic [15:0]         range_out_reg;
    logic [14:0]         z_limit_reg;
    logic                sx_reg;
    logic                sy_reg;
    logic [8:0]          beam_reg;
    logic                ok_reg;
    logic [AW-1:0]       addr_reg;
    logic [15:0]         range_reg;

    logic                in_acc;
    logic                out_free;
    logic [15:0]         ax;
    logic [15:0]         ay;
    logic [15:0]         az;
    logic                z_over;
    logic                geom_start;
    logic                drain_ok;
    pcls_pkg::geom_res_t geom_res;
    logic [6:0]          fl;
    logic [7:0]          ce;
    logic [9:0]          bin;
    logic                keep;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [15:0]         mem_rd_data;
    logic                mem_wr_en;
    logic [15:0]         mem_wr_data;
    logic                mem_busy;

    // Handshakes
    assign in_stall  = (state_reg != S_IDLE) || mem_busy;
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign beam_number = beam_out_reg;
    assign range_mm    = range_out_reg;
    assign hit         = (range_out_reg != pcls_pkg::EMPTY_RANGE);

    // Magnitudes and height gate
    assign ax         = x_mm[15] ? 16'(-x_mm) : x_mm;
    assign ay         = y_mm[15] ? 16'(-y_mm) : y_mm;
    assign az         = z_mm[15] ? 16'(-z_mm) : z_mm;
    assign z_over     = (az > {1'b0, z_limit_reg});
    assign geom_start = in_acc && (opcode == pcls_pkg::OP_ADD) && !z_over;
    assign drain_ok   = (32'(drain_beam) < BEAMS);

    // Quadrant fold of the angle code into a beam index
    always_comb
    begin
        fl = geom_res.code[7:1];
        ce = 8'(fl) + 8'(geom_res.code[0]);
        unique case ({sy_reg, sx_reg})
            2'b00:   bin = pcls_pkg::HALF_TURN + 10'(fl);
            2'b01:   bin = pcls_pkg::FULL_TURN - 10'(ce);
            2'b10:   bin = pcls_pkg::HALF_TURN - 10'(ce);
            default: bin = 10'(fl);
        endcase
        keep = (bin < pcls_pkg::FULL_TURN) && (32'(bin) < BEAMS);
    end

    // Store requests
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = AW'(drain_beam);
        if (state_reg == S_IDLE)
            mem_rd_en = in_acc && (opcode == pcls_pkg::OP_DRAIN) && drain_ok;
        else if (state_reg == S_GEOM)
        begin
            mem_rd_en   = geom_res.done && keep;
            mem_rd_addr = AW'(bin);
        end
        mem_wr_en   = ((state_reg == S_UPD) && (range_reg < mem_rd_data)) ||
                      ((state_reg == S_DRAIN) && out_free && ok_reg);
        mem_wr_data = (state_reg == S_UPD) ? range_reg : pcls_pkg::EMPTY_RANGE;
    end

    pcls_geom u_geom
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (geom_start),
        .ax    (ax),
        .ay    (ay),
        .res   (geom_res)
    );

    pcls_mem #(.BEAMS(BEAMS), .AW(AW)) u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (addr_reg),
        .wr_data (mem_wr_data),
        .busy    (mem_busy)
    );

    // Sequencer, config register and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            beam_out_reg  <= '0;
            range_out_reg <= pcls_pkg::EMPTY_RANGE;
            z_limit_reg   <= pcls_pkg::Z_LIMIT_RST;
            sx_reg        <= 1'b0;
            sy_reg        <= 1'b0;
            beam_reg      <= '0;
            ok_reg        <= 1'b0;
            addr_reg      <= '0;
            range_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                z_limit_reg <= z_limit_mm;
            // A drain that loads a new word sets valid below
            if (out_valid_reg && !out_stall && (state_reg != S_DRAIN))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        sx_reg   <= x_mm[15];
                        sy_reg   <= y_mm[15];
                        beam_reg <= drain_beam;
                        ok_reg   <= drain_ok;
                        addr_reg <= AW'(drain_beam);
                        if (opcode == pcls_pkg::OP_DRAIN)
                            state_reg <= S_DRAIN;
                        else if (!z_over)
                            state_reg <= S_GEOM;
                    end
                end
                S_GEOM:
                begin
                    if (geom_res.done)
                    begin
                        addr_reg  <= AW'(bin);
                        range_reg <= geom_res.range;
                        state_reg <= keep ? S_UPD : S_IDLE;
                    end
                end
                S_UPD:
                begin
                    state_reg <= S_IDLE;
                end
                S_DRAIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        beam_out_reg  <= beam_reg;
                        range_out_reg <= ok_reg ? mem_rd_data : pcls_pkg::EMPTY_RANGE;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Items enter only when idle and the store is swept
    a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (state_reg == S_IDLE) && !mem_busy)
        else $error("item accepted while busy");

    // Geometry results arrive only while waiting for them
    a_geom_done: assert property (@(posedge clk) disable iff (!rst_n)
        geom_res.done |-> (state_reg == S_GEOM))
        else $error("geometry result outside wait state");

    // A new output word comes only from a drain
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DRAIN)
        else $error("output word without drain");

    // An update follows a store read issued in the cycle before it
    a_upd_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> $past(mem_rd_en))
        else $error("update without store read");

endmodule
